// File: src/id3u8_pkg.sv
// ----------------------------------------------------------------------------
// id3u8_pkg
// Shared types and constants of the ID3 text to UTF-8 transcoder.
// ----------------------------------------------------------------------------
`default_nettype none

package id3u8_pkg;

	// Default width of the written byte counter.
	localparam int ID3U8_COUNT_BITS = 16;

	// Depth of the queue between the classifier and the byte emitter.
	localparam int ID3U8_QUEUE_DEPTH = 2;

	// Reset value of the capacity register.
	localparam logic [15:0] CAP_RESET = 16'd64;

	// Register map: index of each configuration register.
	localparam logic REG_OUT_CAPACITY = 1'b0;

	// Encoding codes carried by the first byte of a payload.
	localparam logic [7:0] ENC_LATIN1   = 8'h00;
	localparam logic [7:0] ENC_UTF16_LE = 8'h01;
	localparam logic [7:0] ENC_UTF16_BE = 8'h02;

	// Byte order mark bytes.
	localparam logic [7:0] BOM_FF = 8'hFF;
	localparam logic [7:0] BOM_FE = 8'hFE;

	// Top six bits of high and low surrogate code units.
	localparam logic [5:0] SUR_HI_TAG = 6'h36;
	localparam logic [5:0] SUR_LO_TAG = 6'h37;

	// UTF-8 lead and continuation prefixes.
	localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
	localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
	localparam logic [7:0] UTF8_LEAD4 = 8'hF0;
	localparam logic [7:0] UTF8_CONT  = 8'h80;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} out_item_t;

	// One classified input item: up to three code points, each with its
	// encoded length (zero marks an unused slot; slots fill in order), and
	// whether the terminator follows them.
	typedef struct packed {
		logic [2:0][20:0] cp;
		logic [2:0][2:0]  len;
		logic             term;
	} id3u8_entry_t;

endpackage

`default_nettype wire

// File: src/id3u8_front.sv
// ----------------------------------------------------------------------------
// id3u8_front
// Accepts payload bytes, tracks the decoding state and emits one entry per
// item that releases code points within the capacity limit or ends a payload.
// ----------------------------------------------------------------------------
`default_nettype none

module id3u8_front
	import id3u8_pkg::*;
#(
	parameter int COUNT_BITS = ID3U8_COUNT_BITS
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_stall,
	input  wire in_item_t     in_item,
	input  wire logic [15:0]  out_capacity,
	input  wire logic         q_full,
	output logic              push,
	output id3u8_entry_t      push_entry
);

	localparam int LW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

	typedef enum logic [1:0] {
		PH_CODE,
		PH_LATIN,
		PH_UTF16,
		PH_PASS
	} phase_t;

	typedef struct packed {
		id3u8_entry_t ent;
		logic [1:0]   k;
		logic [3:0]   sum;
		logic         halted;
		logic         ok;
	} work_t;

	function automatic logic [2:0] cp_len(input logic [20:0] cp);
		logic [2:0] n;
		if (cp < 21'h80)
			n = 3'd1;
		else if (cp < 21'h800)
			n = 3'd2;
		else if (cp < 21'h10000)
			n = 3'd3;
		else
			n = 3'd4;
		return n;
	endfunction

	// Appends one character if it still fits, otherwise halts the text.
	function automatic work_t attempt(input work_t w, input logic [20:0] cp,
			input logic [2:0] n, input logic [LW:0] wc_x, input logic [LW:0] lim_x);
		work_t r;
		r = w;
		r.ok = 1'b0;
		if (wc_x + (LW+1)'(w.sum) + (LW+1)'(n) > lim_x) begin
			r.halted = 1'b1;
		end else begin
			r.ent.cp[w.k]  = cp;
			r.ent.len[w.k] = n;
			r.k            = w.k + 2'd1;
			r.sum          = w.sum + 4'(n);
			r.ok           = 1'b1;
		end
		return r;
	endfunction

	phase_t                  phase_q, phase_n;
	logic                    order_big_q, order_big_n;
	logic                    first_unit_q, first_unit_n;
	logic [7:0]              held_byte_q, held_byte_n;
	logic                    held_valid_q, held_valid_n;
	logic [9:0]              high_sur_q, high_sur_n;
	logic                    sur_wait_q, sur_wait_n;
	logic [COUNT_BITS-1:0]   wc_q, wc_n;
	logic                    halted_q, halted_n;

	logic                    accept;
	logic [15:0]             cap_m1;
	logic [LW:0]             cap_x;
	logic [LW:0]             cmax_x;
	logic [LW:0]             lim_x;
	logic [LW:0]             wc_x;
	work_t                   w;
	logic [7:0]              b;
	logic [15:0]             u;
	logic                    bom;
	logic                    stop;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	// Text limit: capacity minus one, also capped by the counter range.
	assign cap_m1 = (out_capacity == 16'd0) ? 16'd0 : out_capacity - 16'd1;
	assign cap_x  = (LW+1)'(cap_m1);
	assign cmax_x = ((LW+1)'(1) << COUNT_BITS) - (LW+1)'(1);
	assign lim_x  = (cap_x > cmax_x) ? cmax_x : cap_x;
	assign wc_x   = (LW+1)'(wc_q);

	always_comb begin
		phase_n      = phase_q;
		order_big_n  = order_big_q;
		first_unit_n = first_unit_q;
		held_byte_n  = held_byte_q;
		held_valid_n = held_valid_q;
		high_sur_n   = high_sur_q;
		sur_wait_n   = sur_wait_q;
		wc_n         = wc_q;
		halted_n     = halted_q;
		w            = '0;
		w.halted     = halted_q;
		b            = in_item.data_byte;
		u            = '0;
		bom          = 1'b0;
		stop         = 1'b0;

		if (accept) begin
			if (phase_q == PH_CODE) begin
				case (b)
					ENC_LATIN1: begin
						phase_n = PH_LATIN;
					end
					ENC_UTF16_LE: begin
						phase_n     = PH_UTF16;
						order_big_n = 1'b0;
					end
					ENC_UTF16_BE: begin
						phase_n     = PH_UTF16;
						order_big_n = 1'b1;
					end
					default: begin
						phase_n = PH_PASS;
					end
				endcase
			end else if (!halted_q) begin
				case (phase_q)
					PH_LATIN: begin
						if (b == 8'd0)
							w.halted = 1'b1;
						else
							w = attempt(w, 21'(b), b[7] ? 3'd2 : 3'd1, wc_x, lim_x);
					end
					PH_UTF16: begin
						if (!held_valid_q) begin
							held_byte_n  = b;
							held_valid_n = 1'b1;
						end else begin
							held_valid_n = 1'b0;
							if (first_unit_q) begin
								first_unit_n = 1'b0;
								if (held_byte_q == BOM_FF && b == BOM_FE) begin
									order_big_n = 1'b0;
									bom         = 1'b1;
								end else if (held_byte_q == BOM_FE && b == BOM_FF) begin
									order_big_n = 1'b1;
									bom         = 1'b1;
								end
							end
							if (!bom) begin
								u = order_big_q ? {held_byte_q, b} : {b, held_byte_q};
								if (sur_wait_q) begin
									sur_wait_n = 1'b0;
									if (u[15:10] == SUR_LO_TAG) begin
										w = attempt(w, 21'h10000 + {1'b0, high_sur_q, u[9:0]},
											3'd4, wc_x, lim_x);
										stop = 1'b1;
									end else begin
										w = attempt(w, {5'd0, SUR_HI_TAG, high_sur_q}, 3'd3,
											wc_x, lim_x);
										stop = !w.ok;
									end
								end
								if (!stop) begin
									if (u == 16'd0) begin
										w.halted = 1'b1;
									end else if (u[15:10] == SUR_HI_TAG) begin
										high_sur_n = u[9:0];
										sur_wait_n = 1'b1;
									end else begin
										w = attempt(w, 21'(u), cp_len(21'(u)), wc_x, lim_x);
									end
								end
							end
						end
					end
					PH_PASS: begin
						if (b == 8'd0)
							w.halted = 1'b1;
						else
							w = attempt(w, 21'(b), 3'd1, wc_x, lim_x);
					end
					default: begin
					end
				endcase
			end

			if (in_item.last_byte) begin
				// A high surrogate still waiting at the end is encoded alone.
				if (phase_n == PH_UTF16 && !w.halted && sur_wait_n)
					w = attempt(w, {5'd0, SUR_HI_TAG, high_sur_n}, 3'd3, wc_x, lim_x);
				w.ent.term   = 1'b1;
				phase_n      = PH_CODE;
				order_big_n  = 1'b0;
				first_unit_n = 1'b1;
				held_byte_n  = 8'd0;
				held_valid_n = 1'b0;
				high_sur_n   = 10'd0;
				sur_wait_n   = 1'b0;
				wc_n         = '0;
				halted_n     = 1'b0;
			end else begin
				wc_n     = wc_q + COUNT_BITS'(w.sum);
				halted_n = w.halted;
			end
		end
	end

	assign push       = accept && (w.k != 2'd0 || w.ent.term);
	assign push_entry = w.ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_CODE;
			order_big_q  <= 1'b0;
			first_unit_q <= 1'b1;
			held_byte_q  <= 8'd0;
			held_valid_q <= 1'b0;
			high_sur_q   <= 10'd0;
			sur_wait_q   <= 1'b0;
			wc_q         <= '0;
			halted_q     <= 1'b0;
		end else begin
			phase_q      <= phase_n;
			order_big_q  <= order_big_n;
			first_unit_q <= first_unit_n;
			held_byte_q  <= held_byte_n;
			held_valid_q <= held_valid_n;
			high_sur_q   <= high_sur_n;
			sur_wait_q   <= sur_wait_n;
			wc_q         <= wc_n;
			halted_q     <= halted_n;
		end
	end

endmodule

`default_nettype wire

// File: src/id3u8_queue.sv
// ----------------------------------------------------------------------------
// id3u8_queue
// Small register queue of classified entries between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module id3u8_queue
	import id3u8_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire id3u8_entry_t push_entry,
	output logic              full,
	input  wire logic         pop,
	output logic              head_valid,
	output id3u8_entry_t      head_entry
);

	localparam int PW = (ID3U8_QUEUE_DEPTH > 1) ? $clog2(ID3U8_QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(ID3U8_QUEUE_DEPTH + 1);

	id3u8_entry_t   slot_q [ID3U8_QUEUE_DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full       = (count_q == CW'(ID3U8_QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = slot_q[rd_ptr_q];

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		logic [PW-1:0] r;
		if (p == PW'(ID3U8_QUEUE_DEPTH - 1))
			r = '0;
		else
			r = p + PW'(1);
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

endmodule

`default_nettype wire

// File: src/id3u8_back.sv
// ----------------------------------------------------------------------------
// id3u8_back
// Serializes the head entry into UTF-8 bytes, one per cycle while the output
// is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module id3u8_back
	import id3u8_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         head_valid,
	input  wire id3u8_entry_t head_entry,
	output logic              pop,
	output logic              out_valid,
	input  wire logic         out_stall,
	output out_item_t         out_item
);

	// Position 3 means the terminator of the entry.
	localparam logic [1:0] POS_TERM = 2'd3;

	function automatic logic [7:0] enc_byte(input logic [20:0] cp, input logic [2:0] n,
			input logic [1:0] j);
		logic [7:0] r;
		case (n)
			3'd2: begin
				case (j)
					2'd0:    r = UTF8_LEAD2 | {3'd0, cp[10:6]};
					default: r = UTF8_CONT | {2'd0, cp[5:0]};
				endcase
			end
			3'd3: begin
				case (j)
					2'd0:    r = UTF8_LEAD3 | {4'd0, cp[15:12]};
					2'd1:    r = UTF8_CONT | {2'd0, cp[11:6]};
					default: r = UTF8_CONT | {2'd0, cp[5:0]};
				endcase
			end
			3'd4: begin
				case (j)
					2'd0:    r = UTF8_LEAD4 | {5'd0, cp[20:18]};
					2'd1:    r = UTF8_CONT | {2'd0, cp[17:12]};
					2'd2:    r = UTF8_CONT | {2'd0, cp[11:6]};
					default: r = UTF8_CONT | {2'd0, cp[5:0]};
				endcase
			end
			default: r = cp[7:0];
		endcase
		return r;
	endfunction

	logic [1:0]   pos_q;
	logic [1:0]   idx_q;
	logic         out_valid_q;
	out_item_t    out_item_q;

	logic         advance;
	logic         fire;
	logic [20:0]  cur_cp;
	logic [2:0]   cur_len;
	logic [2:0]   nxt_len;
	logic         in_slot;
	logic         slot_done;
	logic [1:0]   nxt_pos;

	assign advance = !out_valid_q || !out_stall;
	assign fire    = head_valid && advance;

	always_comb begin
		cur_cp  = head_entry.cp[0];
		cur_len = head_entry.len[0];
		nxt_len = head_entry.len[1];
		case (pos_q)
			2'd1: begin
				cur_cp  = head_entry.cp[1];
				cur_len = head_entry.len[1];
				nxt_len = head_entry.len[2];
			end
			2'd2: begin
				cur_cp  = head_entry.cp[2];
				cur_len = head_entry.len[2];
				nxt_len = 3'd0;
			end
			default: begin
			end
		endcase
	end

	assign in_slot   = (pos_q != POS_TERM) && (cur_len != 3'd0);
	assign slot_done = ({1'b0, idx_q} == cur_len - 3'd1);
	assign nxt_pos   = (nxt_len != 3'd0) ? pos_q + 2'd1 : POS_TERM;

	always_comb begin
		pop = 1'b0;
		if (fire) begin
			if (!in_slot)
				pop = 1'b1;
			else if (slot_done && nxt_pos == POS_TERM && !head_entry.term)
				pop = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= 2'd0;
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= head_valid;
			if (head_valid) begin
				if (!in_slot) begin
					pos_q <= 2'd0;
					idx_q <= 2'd0;
				end else if (slot_done) begin
					idx_q <= 2'd0;
					pos_q <= (pop) ? 2'd0 : nxt_pos;
				end else begin
					idx_q <= idx_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			if (in_slot) begin
				out_item_q.out_byte <= enc_byte(cur_cp, cur_len, idx_q);
				out_item_q.out_last <= 1'b0;
			end else begin
				out_item_q.out_byte <= 8'd0;
				out_item_q.out_last <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

`default_nettype wire

// File: src/id3_text_to_utf8_core.sv
// ----------------------------------------------------------------------------
// id3_text_to_utf8_core
// Streaming transcoder of ID3 text payloads (Latin-1, UTF-16, UTF-8) into a
// zero-terminated UTF-8 string.
// ----------------------------------------------------------------------------
// The block takes one payload byte per item, the first byte of each payload
// being the encoding code, and returns the UTF-8 text one byte per item,
// closed by a zero byte with out_last set when the input item carries
// last_byte. The front stage accepts an input item while the queue has
// room: it decodes the byte, pairs UTF-16 bytes into code units, joins
// surrogates and checks every character against the capacity register, so
// the capacity limit is settled before any byte leaves. Each item that
// yields output becomes one entry in a two-entry queue. The back stage turns
// the head entry into UTF-8 bytes at one byte per cycle while out_stall is
// low, through a registered output stage. An item yields at most seven
// bytes (two lone surrogates of three bytes each and the terminator); the
// byte emitter in the back stage sets the sustained rate. A new item is taken
// while the previous one is still being written out, as long as the queue
// has room. The capacity register sits at byte address 0 of the APB port
// and should be written only between items.
// ----------------------------------------------------------------------------
`default_nettype none

module id3_text_to_utf8_core
	import id3u8_pkg::*;
#(
	parameter int COUNT_BITS = ID3U8_COUNT_BITS
) (
	input  wire logic         clk,
	input  wire logic         arst_n,

	// Payload bytes in.
	input  wire logic         in_valid,
	output logic              in_stall,
	input  wire in_item_t     in_item,

	// UTF-8 bytes out.
	output logic              out_valid,
	input  wire logic         out_stall,
	output out_item_t         out_item,

	// Configuration port.
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic [15:0]   out_capacity_q;
	logic          cfg_write;

	logic          q_full;
	logic          push;
	id3u8_entry_t  push_entry;
	logic          pop;
	logic          head_valid;
	id3u8_entry_t  head_entry;

	// The register index is the word address; the low address bits select
	// a byte lane and are ignored.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_OUT_CAPACITY);
	assign prdata    = (paddr[2] == REG_OUT_CAPACITY) ? {16'd0, out_capacity_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_capacity_q <= CAP_RESET;
		end else if (cfg_write) begin
			out_capacity_q <= pwdata[15:0];
		end
	end

	// Front: accepts bytes and resolves characters and the capacity limit.
	id3u8_front #(
		.COUNT_BITS (COUNT_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_item      (in_item),
		.out_capacity (out_capacity_q),
		.q_full       (q_full),
		.push         (push),
		.push_entry   (push_entry)
	);

	// Queue that lets the two halves stall independently.
	id3u8_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	// Back: writes the UTF-8 bytes of each entry one per cycle unless stalled.
	id3u8_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_item   (out_item)
	);

	// The terminator is always a zero byte.
	a_term_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.out_last |-> out_item.out_byte == 8'd0)
		else $error("terminator item carries a nonzero byte");

	// The back stage only retires an entry that is present.
	a_pop_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue popped while empty");

	// The front never writes into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_full && !pop |=> q_full)
		else $error("queue lost its contents while full");

	// An entry always has something to emit.
	a_entry_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (push_entry.len[0] != 3'd0) || push_entry.term)
		else $error("empty entry pushed into the queue");

endmodule

`default_nettype wire

// File: tb/tb_id3_text_to_utf8_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the ID3 text to UTF-8 transcoder.
// ----------------------------------------------------------------------------
// A behavioral transcoder inside this module follows every accepted payload
// byte and queues the UTF-8 bytes that the block has to return. A monitor
// pops that queue for each returned item and compares it field by field.
// A short table of directed payloads comes first, and then random payloads.
// Most random payloads are well formed: Latin-1, UTF-16 with and without
// byte order marks, and passthrough. The rest are noise. Both handshakes
// idle at random. The receiver holds off for a long stretch once. The
// capacity register is rewritten between payloads once the block has
// drained.
// ----------------------------------------------------------------------------

module tb
	import id3u8_pkg::*;
();

	localparam int RANDOM_ITEMS  = 234;
	localparam int DIR_ROWS      = 26;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES  = 20;
	localparam int HOLD_CYCLES   = 250;
	localparam int QUIET_LIMIT   = 3000;
	localparam int PLAN_LEN      = 12;

	localparam out_item_t NO_ITEM   = '0;
	localparam out_item_t TERM_ITEM = '{out_byte: 8'h00, out_last: 1'b1};

	// Payload state of the behavioral transcoder.
	typedef enum logic [1:0] {AWAIT_CODE, TEXT_LATIN1, TEXT_UTF16, TEXT_PASS} text_mode_t;

	// One row of the directed table. n_typed is zero for rows that rely on the
	// behavioral transcoder. Otherwise it gives how many of typed_a and typed_b
	// are the literal result of the row.
	typedef struct packed {
		logic [7:0] data;
		logic       fin;
		logic [1:0] n_typed;
		out_item_t  typed_a;
		out_item_t  typed_b;
	} stim_row_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	in_item_t   in_item;
	logic       out_valid;
	logic       out_stall;
	out_item_t  out_item;
	logic       psel;
	logic       penable;
	logic       pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic       pready;

	id3_text_to_utf8_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// The clock period is 12 ns.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Behavioral transcoder
	// ------------------------------------------------------------------------
	// This is a copy of the block's state. It is kept in step with the items
	// that the block accepts. capacity_reg tracks every register write.
	logic [15:0]  capacity_reg;
	text_mode_t   text_mode;
	logic         unit_msb_first;
	logic         bom_window;
	logic [7:0]   pend_byte;
	logic         pend_valid;
	logic [9:0]   sur_bits;
	logic         sur_pending;
	int unsigned  bytes_written;
	logic         stopped;

	// UTF-8 bytes produced by the payload byte just accepted.
	out_item_t    step_utf8[$];
	// Every UTF-8 byte still owed by the block, oldest first.
	out_item_t    utf8_expected[$];

	function automatic void clear_text_state();
		text_mode      = AWAIT_CODE;
		unit_msb_first = 1'b0;
		bom_window     = 1'b1;
		pend_byte      = 8'h00;
		pend_valid     = 1'b0;
		sur_bits       = 10'd0;
		sur_pending    = 1'b0;
		bytes_written  = 0;
		stopped        = 1'b0;
	endfunction

	// The text may use capacity minus one bytes. A capacity of zero leaves
	// room for the terminator alone.
	function automatic int unsigned text_room();
		return (capacity_reg == 16'd0) ? 32'd0 : {16'd0, capacity_reg} - 32'd1;
	endfunction

	function automatic void put_utf8(input logic [7:0] b, input logic fin);
		step_utf8.push_back('{out_byte: b, out_last: fin});
	endfunction

	// Encodes one code point. If the whole character does not fit in the
	// room left, it writes nothing, sets the halt flag and returns 0.
	function automatic bit emit_char(input logic [20:0] cp);
		int unsigned n;
		n = (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
		if (bytes_written + n > text_room()) begin
			stopped = 1'b1;
			return 1'b0;
		end
		bytes_written += n;
		case (n)
		1: put_utf8(cp[7:0], 1'b0);
		2: begin
			put_utf8(UTF8_LEAD2 | {3'b000, cp[10:6]}, 1'b0);
			put_utf8(UTF8_CONT | {2'b00, cp[5:0]}, 1'b0);
		end
		3: begin
			put_utf8(UTF8_LEAD3 | {4'b0000, cp[15:12]}, 1'b0);
			put_utf8(UTF8_CONT | {2'b00, cp[11:6]}, 1'b0);
			put_utf8(UTF8_CONT | {2'b00, cp[5:0]}, 1'b0);
		end
		default: begin
			put_utf8(UTF8_LEAD4 | {5'b00000, cp[20:18]}, 1'b0);
			put_utf8(UTF8_CONT | {2'b00, cp[17:12]}, 1'b0);
			put_utf8(UTF8_CONT | {2'b00, cp[11:6]}, 1'b0);
			put_utf8(UTF8_CONT | {2'b00, cp[5:0]}, 1'b0);
		end
		endcase
		return 1'b1;
	endfunction

	// Handles one UTF-16 code unit. A waiting high surrogate joins a low
	// surrogate. Followed by anything else, it is written alone first.
	function automatic void take_unit(input logic [15:0] u);
		if (sur_pending) begin
			sur_pending = 1'b0;
			if (u[15:10] == SUR_LO_TAG) begin
				void'(emit_char(21'h10000 + {1'b0, sur_bits, u[9:0]}));
				return;
			end
			if (!emit_char({5'd0, SUR_HI_TAG, sur_bits}))
				return;
		end
		if (u == 16'h0000) begin
			stopped = 1'b1;
			return;
		end
		if (u[15:10] == SUR_HI_TAG) begin
			sur_bits    = u[9:0];
			sur_pending = 1'b1;
			return;
		end
		void'(emit_char({5'd0, u}));
	endfunction

	// Pairs bytes into units. In the first unit of a payload, a byte order
	// mark sets the byte order and is not written.
	function automatic void take_utf16_byte(input logic [7:0] b);
		if (!pend_valid) begin
			pend_byte  = b;
			pend_valid = 1'b1;
			return;
		end
		pend_valid = 1'b0;
		if (bom_window) begin
			bom_window = 1'b0;
			if (pend_byte == BOM_FF && b == BOM_FE) begin
				unit_msb_first = 1'b0;
				return;
			end
			if (pend_byte == BOM_FE && b == BOM_FF) begin
				unit_msb_first = 1'b1;
				return;
			end
		end
		take_unit(unit_msb_first ? {pend_byte, b} : {b, pend_byte});
	endfunction

	// Works out the UTF-8 bytes of one accepted payload byte into step_utf8.
	function automatic void transcode_byte(input logic [7:0] b, input logic fin);
		step_utf8.delete();
		if (text_mode == AWAIT_CODE) begin
			case (b)
			ENC_LATIN1: text_mode = TEXT_LATIN1;
			ENC_UTF16_LE: begin
				text_mode      = TEXT_UTF16;
				unit_msb_first = 1'b0;
			end
			ENC_UTF16_BE: begin
				text_mode      = TEXT_UTF16;
				unit_msb_first = 1'b1;
			end
			default: text_mode = TEXT_PASS;
			endcase
		end else if (!stopped) begin
			case (text_mode)
			TEXT_LATIN1: begin
				if (b == 8'h00)
					stopped = 1'b1;
				else
					void'(emit_char({13'd0, b}));
			end
			TEXT_UTF16: take_utf16_byte(b);
			default: begin
				// Passthrough copies bytes one at a time. This can cut a
				// multi-byte character at the capacity limit.
				if (b == 8'h00 || bytes_written + 1 > text_room()) begin
					stopped = 1'b1;
				end else begin
					bytes_written++;
					put_utf8(b, 1'b0);
				end
			end
			endcase
		end
		if (fin) begin
			// A high surrogate still waiting at the end is written alone.
			// A held odd byte is dropped.
			if (text_mode == TEXT_UTF16 && !stopped && sur_pending) begin
				sur_pending = 1'b0;
				void'(emit_char({5'd0, SUR_HI_TAG, sur_bits}));
			end
			put_utf8(8'h00, 1'b1);
			clear_text_state();
		end
	endfunction

	// ------------------------------------------------------------------------
	// Counters and output checking
	// ------------------------------------------------------------------------
	int items_accepted = 0;
	int results_seen   = 0;
	int payloads_sent  = 0;
	int failures       = 0;
	int quiet_cycles   = 0;

	// Sender and receiver settings. The sender sets gaps_on and hold_request.
	// The receiver process clears hold_request when it begins the long hold.
	bit gaps_on      = 1'b1;
	bit hold_request = 1'b0;

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			items_accepted++;
	end

	// Each returned item is compared with the oldest expectation. The run
	// goes on after a mismatch so that later ones are reported too.
	always @(posedge clk) begin : check_out
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (utf8_expected.size() == 0) begin
				$error("out_byte: expected nothing, got %02h (out_last %0b)",
					out_item.out_byte, out_item.out_last);
				failures++;
			end else begin
				want = utf8_expected.pop_front();
				if (out_item.out_byte !== want.out_byte) begin
					$error("out_byte: expected %02h, got %02h", want.out_byte, out_item.out_byte);
					failures++;
				end
				if (out_item.out_last !== want.out_last) begin
					$error("out_last: expected %0b, got %0b", want.out_last, out_item.out_last);
					failures++;
				end
			end
		end
	end

	// The watchdog stops the run if no item moves on either side for too long.
	// The long receiver hold and the register write pauses are far shorter
	// than this limit.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("timeout: nothing moved for %0d cycles, %0d bytes still owed",
					QUIET_LIMIT, utf8_expected.size());
				$display("id3_text_to_utf8_core test failed");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Receiver
	// ------------------------------------------------------------------------
	// Mostly, the receiver stalls at random, about 8 percent of the time.
	// Outside the long hold, it never stalls while results 100 to 249 go by.
	// When asked once, it holds off for HOLD_CYCLES. The block then fills up
	// and has to stall its input while the sender keeps offering bytes.
	initial begin : sink
		int hold_left;
		hold_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (results_seen >= 100 && results_seen < 250) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(0, 99) < 8);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Sender
	// ------------------------------------------------------------------------
	logic [7:0] payload_q[$];
	logic       build_big;

	// Offers one byte, starting at a falling edge, and waits until it is
	// accepted. The expectation is queued at the edge that accepts the byte.
	// The task returns at the next falling edge with in_valid still high. The
	// next call, or the caller, sets it there.
	task automatic send_byte(input stim_row_t row);
		if (gaps_on)
			while ($urandom_range(0, 99) < 8) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
		in_item  <= '{data_byte: row.data, last_byte: row.fin};
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		transcode_byte(row.data, row.fin);
		if (row.n_typed == 2'd0) begin
			foreach (step_utf8[j])
				utf8_expected.push_back(step_utf8[j]);
		end else begin
			utf8_expected.push_back(row.typed_a);
			if (row.n_typed == 2'd2)
				utf8_expected.push_back(row.typed_b);
		end
		@(negedge clk);
	endtask

	task automatic send_payload();
		for (int j = 0; j < payload_q.size(); j++)
			send_byte('{payload_q[j], j == payload_q.size() - 1, 2'd0, NO_ITEM, NO_ITEM});
		payloads_sent++;
	endtask

	// Waits until every owed byte has come back, lets the pipeline settle,
	// and then writes the capacity register. The write has a setup phase and
	// an access phase.
	task automatic set_capacity(input logic [15:0] cap);
		in_valid <= 1'b0;
		while (utf8_expected.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_OUT_CAPACITY, 2'b00};
		pwdata  <= {16'd0, cap};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		capacity_reg = cap;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	function automatic void add_unit(input logic [15:0] u);
		if (build_big) begin
			payload_q.push_back(u[15:8]);
			payload_q.push_back(u[7:0]);
		end else begin
			payload_q.push_back(u[7:0]);
			payload_q.push_back(u[15:8]);
		end
	endfunction

	// Adds one UTF-16 character, with the cases weighted toward the
	// interesting ones. These are surrogate pairs, lone high and low
	// surrogates, each UTF-8 length, and now and then a zero unit.
	task automatic add_random_char();
		logic [19:0] sup;
		case ($urandom_range(0, 7))
		0: add_unit(16'($urandom_range('h20, 'h7E)));
		1: add_unit(16'($urandom_range('h80, 'h7FF)));
		2: add_unit(16'($urandom_range('h800, 'hD7FF)));
		3: add_unit(16'($urandom_range('hE000, 'hFFFF)));
		4: begin
			sup = 20'($urandom);
			add_unit({SUR_HI_TAG, sup[19:10]});
			add_unit({SUR_LO_TAG, sup[9:0]});
		end
		5: add_unit({SUR_HI_TAG, 10'($urandom)});
		6: add_unit({SUR_LO_TAG, 10'($urandom)});
		default: add_unit(($urandom_range(0, 11) == 0) ? 16'h0000 : 16'($urandom));
		endcase
	endtask

	// Builds one payload in payload_q. Most payloads are well formed with
	// random content. About one in ten is noise.
	task automatic build_random_payload();
		int kind;
		int len;
		kind = $urandom_range(0, 9);
		payload_q.delete();
		if (kind <= 1) begin
			payload_q.push_back(ENC_LATIN1);
			len = $urandom_range(0, 10);
			repeat (len)
				payload_q.push_back(($urandom_range(0, 14) == 0) ? 8'h00 :
					8'($urandom_range(1, 255)));
		end else if (kind <= 6) begin
			build_big = 1'($urandom_range(0, 1));
			payload_q.push_back(build_big ? ENC_UTF16_BE : ENC_UTF16_LE);
			if ($urandom_range(0, 2) == 0) begin
				// The mark overrides the order that the encoding code implies.
				build_big = 1'($urandom_range(0, 1));
				if (build_big) begin
					payload_q.push_back(BOM_FE);
					payload_q.push_back(BOM_FF);
				end else begin
					payload_q.push_back(BOM_FF);
					payload_q.push_back(BOM_FE);
				end
			end
			len = $urandom_range(0, 5);
			repeat (len)
				add_random_char();
			if ($urandom_range(0, 4) == 0)
				payload_q.push_back(8'($urandom));
		end else if (kind <= 8) begin
			payload_q.push_back(8'($urandom_range(3, 255)));
			len = $urandom_range(0, 12);
			repeat (len)
				payload_q.push_back(($urandom_range(0, 14) == 0) ? 8'h00 :
					8'($urandom_range(1, 255)));
		end else begin
			len = $urandom_range(0, 8);
			repeat (len + 1)
				payload_q.push_back(8'($urandom));
		end
	endtask

	// Capacities used for the random part in turn. The list holds the
	// extremes 0 and 65535 and keeps most values small, so that halting at
	// the capacity limit comes up often.
	int unsigned cap_plan [PLAN_LEN] = '{1, 65535, 3, 0, 9, 2, 24, 5, 64, 7, 65535, 12};

	stim_row_t directed_rows [DIR_ROWS];

	initial begin : stimulus
		int  random_sent;
		int  plan_idx;
		bit  pressure_done;

		arst_n    = 1'b0;
		in_valid <= 1'b0;
		in_item  <= '0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		capacity_reg = CAP_RESET;
		clear_text_state();

		// The directed payloads run at the reset capacity. Typed rows can be
		// read off directly: a code byte that is also the last byte, a two
		// byte Latin-1 character, and terminators after the text has ended.
		directed_rows = '{
			// A code byte flagged last gives only the terminator.
			'{ENC_LATIN1, 1'b1, 2'd1, TERM_ITEM, NO_ITEM},
			// Latin-1: top byte, zero byte ends the text, later bytes dropped.
			'{ENC_LATIN1, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
			'{8'hFF, 1'b0, 2'd2, '{8'hC3, 1'b0}, '{8'hBF, 1'b0}},
			'{8'h00, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
			'{8'h55, 1'b1, 2'd1, TERM_ITEM, NO_ITEM},
			// UTF-16 flagged little endian with a big endian mark, a
			// surrogate pair, then a high surrogate left unpaired at the end
			// with an odd trailing byte.
			'{ENC_UTF16_LE, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
			'{BOM_FE, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
			'{BOM_FF, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
			'{8'hD8, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
			'{8'h3D, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
			'{8'hDE, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
			'{8'h00, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
			'{8'hDB, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
			'{8'hFF, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
			'{8'h12, 1'b1, 2'd0, NO_ITEM, NO_ITEM},
			// UTF-16 flagged big endian with a little endian mark, a lone
			// low surrogate, then a zero unit on the last byte.
			'{ENC_UTF16_BE, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
			'{BOM_FF, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
			'{BOM_FE, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
			'{8'h00, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
			'{8'hDC, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
			'{8'h00, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
			'{8'h00, 1'b1, 2'd1, TERM_ITEM, NO_ITEM},
			// Passthrough stops at the first zero byte.
			'{8'h03, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
			'{8'hE2, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
			'{8'h00, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
			'{8'h99, 1'b1, 2'd1, TERM_ITEM, NO_ITEM}
		};

		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			send_byte(directed_rows[i]);
			if (directed_rows[i].fin)
				payloads_sent++;
		end

		// In the random part, the capacity changes every third payload. The
		// sender has no gaps for a stretch of about sixty bytes. One long
		// Latin-1 payload runs while the receiver holds off.
		random_sent   = 0;
		plan_idx      = 0;
		pressure_done = 1'b0;
		while (random_sent < RANDOM_ITEMS) begin
			gaps_on = !(random_sent >= 60 && random_sent < 120);
			if (payloads_sent % 3 == 0) begin
				set_capacity(16'(cap_plan[plan_idx % PLAN_LEN]));
				plan_idx++;
			end
			if (!pressure_done && random_sent >= 150) begin
				set_capacity(16'd400);
				pressure_done = 1'b1;
				hold_request  = 1'b1;
				payload_q.delete();
				payload_q.push_back(ENC_LATIN1);
				repeat (30)
					payload_q.push_back(8'($urandom_range(1, 255)));
			end else begin
				build_random_payload();
			end
			send_payload();
			random_sent += payload_q.size();
		end
		in_valid <= 1'b0;

		// Wait for every owed byte. A stray extra byte in the last cycles is
		// still caught by the monitor. The watchdog catches a hang.
		while (utf8_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d payload bytes in %0d payloads and checked %0d UTF-8 bytes.",
			items_accepted, payloads_sent, results_seen);
		$display("Covered Latin-1, UTF-16 with marks and surrogates, passthrough, %s",
			"noise and capacities from 0 to 65535.");
		if (failures == 0)
			$display("id3_text_to_utf8_core test passed");
		else
			$display("id3_text_to_utf8_core test failed");
		$finish;
	end

endmodule

// File: filelist.f
src/id3u8_pkg.sv
src/id3u8_front.sv
src/id3u8_queue.sv
src/id3u8_back.sv
src/id3_text_to_utf8_core.sv
tb/tb_id3_text_to_utf8_core.sv
